[rtl/core/wmpa_pkg.sv]
// Shared types, widths and codes for the window max pool with argmax core.
package wmpa_pkg;

  // Stream field widths
  localparam int ROW_W       = 6;
  localparam int COL_W       = 6;
  localparam int CH_W        = 2;
  localparam int SAMPLE_W    = 32;
  localparam int IDX_W       = 6;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Configuration register widths
  localparam int DIM_W    = 6;
  localparam int CCNT_W   = 3;
  localparam int KSIZE_W  = 4;
  localparam int STRIDE_W = 4;
  localparam int PAD_W    = 3;

  // Signed window coordinate: row * stride - pad fits in 12 bits
  localparam int COORD_W = 12;

  // Default sizing of the store and the window
  localparam int DEF_MAX_HEIGHT   = 32;
  localparam int DEF_MAX_WIDTH    = 32;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_MAX_KERNEL   = 8;
  localparam int DEF_DATA_WIDTH   = 32;

  // Register reset values
  localparam logic [DIM_W-1:0]    RST_MAP_HEIGHT    = 6'd32;
  localparam logic [DIM_W-1:0]    RST_MAP_WIDTH     = 6'd32;
  localparam logic [CCNT_W-1:0]   RST_CHANNEL_COUNT = 3'd1;
  localparam logic [KSIZE_W-1:0]  RST_KERNEL_SIZE   = 4'd2;
  localparam logic [STRIDE_W-1:0] RST_WINDOW_STRIDE = 4'd2;
  localparam logic [PAD_W-1:0]    RST_PAD_AMOUNT    = 3'd0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_MAP_HEIGHT    = 3'd0,
    REG_MAP_WIDTH     = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_KERNEL_SIZE   = 3'd3,
    REG_WINDOW_STRIDE = 3'd4,
    REG_PAD_AMOUNT    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]    map_height;
    logic [DIM_W-1:0]    map_width;
    logic [CCNT_W-1:0]   channel_count;
    logic [KSIZE_W-1:0]  kernel_size;
    logic [STRIDE_W-1:0] window_stride;
    logic [PAD_W-1:0]    pad_amount;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch a query and set up the window scan
    logic write;    // store the sample of an accepted write
    logic step;     // issue one window read and advance the scan
    logic finish;   // move the final maximum into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // the read issued this cycle is the last of the window
    logic out_free;   // output register can take a result at this edge
  } dp_sts_t;

endpackage

[rtl/core/wmpa_regs.sv]
// Configuration register file behind the APB-style port.
module wmpa_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wmpa_pkg::PADDR_W-1:0]   paddr,
  input  logic [wmpa_pkg::PDATA_W-1:0]   pwdata,
  output logic [wmpa_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output wmpa_pkg::cfg_t                 cfg
);

  wmpa_pkg::reg_idx_t reg_sel;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_sel = wmpa_pkg::reg_idx_t'(paddr[wmpa_pkg::PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_height    <= wmpa_pkg::RST_MAP_HEIGHT;
      cfg.map_width     <= wmpa_pkg::RST_MAP_WIDTH;
      cfg.channel_count <= wmpa_pkg::RST_CHANNEL_COUNT;
      cfg.kernel_size   <= wmpa_pkg::RST_KERNEL_SIZE;
      cfg.window_stride <= wmpa_pkg::RST_WINDOW_STRIDE;
      cfg.pad_amount    <= wmpa_pkg::RST_PAD_AMOUNT;
    end else if (wr_en) begin
      case (reg_sel)
        wmpa_pkg::REG_MAP_HEIGHT:    cfg.map_height    <= pwdata[wmpa_pkg::DIM_W-1:0];
        wmpa_pkg::REG_MAP_WIDTH:     cfg.map_width     <= pwdata[wmpa_pkg::DIM_W-1:0];
        wmpa_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[wmpa_pkg::CCNT_W-1:0];
        wmpa_pkg::REG_KERNEL_SIZE:   cfg.kernel_size   <= pwdata[wmpa_pkg::KSIZE_W-1:0];
        wmpa_pkg::REG_WINDOW_STRIDE: cfg.window_stride <= pwdata[wmpa_pkg::STRIDE_W-1:0];
        wmpa_pkg::REG_PAD_AMOUNT:    cfg.pad_amount    <= pwdata[wmpa_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      wmpa_pkg::REG_MAP_HEIGHT:    prdata = wmpa_pkg::PDATA_W'(cfg.map_height);
      wmpa_pkg::REG_MAP_WIDTH:     prdata = wmpa_pkg::PDATA_W'(cfg.map_width);
      wmpa_pkg::REG_CHANNEL_COUNT: prdata = wmpa_pkg::PDATA_W'(cfg.channel_count);
      wmpa_pkg::REG_KERNEL_SIZE:   prdata = wmpa_pkg::PDATA_W'(cfg.kernel_size);
      wmpa_pkg::REG_WINDOW_STRIDE: prdata = wmpa_pkg::PDATA_W'(cfg.window_stride);
      wmpa_pkg::REG_PAD_AMOUNT:    prdata = wmpa_pkg::PDATA_W'(cfg.pad_amount);
      default:                     prdata = '0;
    endcase
  end

endmodule

[rtl/core/wmpa_ctrl.sv]
// Controller state machine: accepts items and sequences the window scan.
module wmpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  wmpa_pkg::op_t     op,
  input  wmpa_pkg::dp_sts_t sts,
  output wmpa_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_LOAD
  } state_t;

  state_t state;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.capture = accept && (op == wmpa_pkg::OP_QUERY);
    cmd.write   = accept && (op == wmpa_pkg::OP_WRITE);
    cmd.step    = (state == ST_SCAN);
    cmd.finish  = (state == ST_LOAD) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.capture) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (sts.scan_last) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          // last read data is compared in this cycle
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/wmpa_dp.sv]
// Datapath: feature store, window address walk, running max and output register.
module wmpa_dp #(
  parameter int MAX_HEIGHT   = wmpa_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH    = wmpa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = wmpa_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_KERNEL   = wmpa_pkg::DEF_MAX_KERNEL,
  parameter int DATA_WIDTH   = wmpa_pkg::DEF_DATA_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wmpa_pkg::dp_cmd_t                    cmd,
  output wmpa_pkg::dp_sts_t                    sts,
  input  wmpa_pkg::cfg_t                       cfg,
  input  logic [wmpa_pkg::ROW_W-1:0]           row_pos,
  input  logic [wmpa_pkg::COL_W-1:0]           col_pos,
  input  logic [wmpa_pkg::CH_W-1:0]            channel_sel,
  input  logic signed [wmpa_pkg::SAMPLE_W-1:0] sample_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wmpa_pkg::SAMPLE_W-1:0] max_value,
  output logic [wmpa_pkg::IDX_W-1:0]           max_index
);

  localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
  localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KCNT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int PROD_W = wmpa_pkg::ROW_W + wmpa_pkg::STRIDE_W;
  localparam int CW     = wmpa_pkg::COORD_W;
  localparam int KW     = wmpa_pkg::KSIZE_W;

  // Effective dimensions after saturation
  logic [wmpa_pkg::DIM_W-1:0]  h_eff;
  logic [wmpa_pkg::DIM_W-1:0]  w_eff;
  logic [wmpa_pkg::CCNT_W-1:0] c_eff;
  logic [KW-1:0]               k_eff;

  always_comb begin
    h_eff = (32'(cfg.map_height) > MAX_HEIGHT) ? wmpa_pkg::DIM_W'(MAX_HEIGHT)
                                               : cfg.map_height;
    w_eff = (32'(cfg.map_width) > MAX_WIDTH) ? wmpa_pkg::DIM_W'(MAX_WIDTH)
                                             : cfg.map_width;
    c_eff = (32'(cfg.channel_count) > MAX_CHANNELS) ? wmpa_pkg::CCNT_W'(MAX_CHANNELS)
                                                    : cfg.channel_count;
    if (cfg.kernel_size == '0)
      k_eff = KW'(1);
    else if (32'(cfg.kernel_size) > MAX_KERNEL)
      k_eff = KW'(MAX_KERNEL);
    else
      k_eff = cfg.kernel_size;
  end

  // Feature store
  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic [MEM_AW-1:0]            wr_addr;
  logic                         wr_ok;
  logic [MEM_AW-1:0]            rd_addr;
  logic signed [DATA_WIDTH-1:0] rd_data;

  assign wr_ok = (row_pos < h_eff) && (col_pos < w_eff) &&
                 ({1'b0, channel_sel} < c_eff);
  assign wr_addr = MEM_AW'((MEM_AW'(row_pos) * MEM_AW'(MAX_WIDTH) + MEM_AW'(col_pos))
                           * MEM_AW'(MAX_CHANNELS) + MEM_AW'(channel_sel));

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) mem[wr_addr] <= DATA_WIDTH'(sample_value);
  end

  always_ff @(posedge clk) begin
    if (cmd.step) rd_data <= mem[rd_addr];
  end

  // Window origin of the query
  logic [PROD_W-1:0]   row_prod;
  logic [PROD_W-1:0]   col_prod;
  logic signed [CW-1:0] row_org;
  logic signed [CW-1:0] col_org;

  assign row_prod = PROD_W'(row_pos) * PROD_W'(cfg.window_stride);
  assign col_prod = PROD_W'(col_pos) * PROD_W'(cfg.window_stride);
  assign row_org  = $signed(CW'(row_prod)) - $signed(CW'(cfg.pad_amount));
  assign col_org  = $signed(CW'(col_prod)) - $signed(CW'(cfg.pad_amount));

  // Scan walk
  logic signed [CW-1:0]         r_cur;
  logic signed [CW-1:0]         q_cur;
  logic signed [CW-1:0]         c_org;
  logic [KCNT_W-1:0]            m_cnt;
  logic [KCNT_W-1:0]            n_cnt;
  logic [wmpa_pkg::IDX_W-1:0]   idx_cnt;
  logic [wmpa_pkg::CH_W-1:0]    qry_ch;
  logic                         ch_ok;
  logic                         n_last;
  logic                         m_last;
  logic                         in_map;

  assign n_last = (KW'(n_cnt) == (k_eff - KW'(1)));
  assign m_last = (KW'(m_cnt) == (k_eff - KW'(1)));
  assign in_map = ch_ok && !r_cur[CW-1] && !q_cur[CW-1] &&
                  ($unsigned(r_cur) < CW'(h_eff)) && ($unsigned(q_cur) < CW'(w_eff));
  assign rd_addr = MEM_AW'((MEM_AW'($unsigned(r_cur)) * MEM_AW'(MAX_WIDTH)
                            + MEM_AW'($unsigned(q_cur))) * MEM_AW'(MAX_CHANNELS)
                           + MEM_AW'(qry_ch));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_cur   <= row_org;
      q_cur   <= col_org;
      c_org   <= col_org;
      m_cnt   <= '0;
      n_cnt   <= '0;
      idx_cnt <= '0;
      qry_ch  <= channel_sel;
      ch_ok   <= ({1'b0, channel_sel} < c_eff);
    end else if (cmd.step) begin
      idx_cnt <= idx_cnt + 1'b1;
      if (n_last) begin
        n_cnt <= '0;
        m_cnt <= m_cnt + 1'b1;
        r_cur <= r_cur + CW'(1);
        q_cur <= c_org;
      end else begin
        n_cnt <= n_cnt + 1'b1;
        q_cur <= q_cur + CW'(1);
      end
    end
  end

  // Read stage tags travel alongside the registered read data
  logic                         rd_valid;
  logic                         rd_zero;
  logic                         rd_first;
  logic [wmpa_pkg::IDX_W-1:0]   rd_idx;
  logic signed [wmpa_pkg::SAMPLE_W-1:0] rd_val;
  logic signed [wmpa_pkg::SAMPLE_W-1:0] best;
  logic [wmpa_pkg::IDX_W-1:0]   best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_zero  <= !in_map;
      rd_first <= (idx_cnt == '0);
      rd_idx   <= idx_cnt;
    end
  end

  // Padding and masked positions compare as zero
  assign rd_val = rd_zero ? '0 : wmpa_pkg::SAMPLE_W'(rd_data);

  always_ff @(posedge clk) begin
    if (rd_valid && (rd_first || (rd_val > best))) begin
      best     <= rd_val;
      best_idx <= rd_idx;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      max_value <= best;
      max_index <= best_idx;
    end
  end

  always_comb begin
    sts.scan_last = n_last && m_last;
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

[rtl/core/window_max_pool_argmax_core.sv]
// Top level of the window max pool with argmax core.
//
// Usage: one channel-interleaved feature map is held in an internal store.
// The slave stream (s_tvalid/s_tready/s_tdata/s_tuser) carries one item per
// transaction; s_tuser selects a sample write (0) or a pooling query (1).
// A write returns nothing; writes outside the configured
// height, width or channel count are dropped. A query scans the k x k
// window one store read per cycle and returns one transaction on the master
// stream (m_tvalid/m_tready/m_tdata) with the maximum and its window index.
// After the query transaction the core scans the window, compares the last read
// in a flush step and moves the result to the output in a load step; only then
// is the result valid and the slave side ready again. The single read port of the store paces the scan.
// The result sits in an output register: further writes are accepted while
// it waits, and a second query finishes its scan and then holds in its load
// step, with the slave side not ready, until the receiver takes the result.
// Reset clears control state and loads register defaults; the store is not
// cleared, and a query must only touch entries written since reset.
// Configuration must be written over the APB-style port only while the core is idle; the block does not enforce this.
module window_max_pool_argmax_core #(
  parameter int MAX_HEIGHT   = wmpa_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH    = wmpa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = wmpa_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_KERNEL   = wmpa_pkg::DEF_MAX_KERNEL,
  parameter int DATA_WIDTH   = wmpa_pkg::DEF_DATA_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [5:0] row_pos, [11:6] col_pos, [13:12] channel_sel,
  // [45:14] sample_value, [47:46] zero
  input  logic [wmpa_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [0] opcode
  input  logic [0:0]                         s_tuser,
  // master stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [31:0] max_value, [37:32] max_index, [39:38] zero
  output logic [wmpa_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wmpa_pkg::PADDR_W-1:0]       paddr,
  input  logic [wmpa_pkg::PDATA_W-1:0]       pwdata,
  output logic [wmpa_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  wmpa_pkg::cfg_t    cfg;
  wmpa_pkg::dp_cmd_t cmd;
  wmpa_pkg::dp_sts_t sts;

  // Unpack the slave payload
  logic [wmpa_pkg::ROW_W-1:0]           row_pos;
  logic [wmpa_pkg::COL_W-1:0]           col_pos;
  logic [wmpa_pkg::CH_W-1:0]            channel_sel;
  logic signed [wmpa_pkg::SAMPLE_W-1:0] sample_value;
  wmpa_pkg::op_t                        op;

  assign row_pos      = s_tdata[5:0];
  assign col_pos      = s_tdata[11:6];
  assign channel_sel  = s_tdata[13:12];
  assign sample_value = $signed(s_tdata[45:14]);
  assign op           = wmpa_pkg::op_t'(s_tuser[0]);

  logic signed [wmpa_pkg::SAMPLE_W-1:0] max_value;
  logic [wmpa_pkg::IDX_W-1:0]           max_index;

  // Pack the master payload, padded to whole bytes
  assign m_tdata = {2'b00, max_index, max_value};

  wmpa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wmpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (op),
    .sts      (sts),
    .cmd      (cmd)
  );

  wmpa_dp #(
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_KERNEL   (MAX_KERNEL),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg          (cfg),
    .row_pos      (row_pos),
    .col_pos      (col_pos),
    .channel_sel  (channel_sel),
    .sample_value (sample_value),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .max_value    (max_value),
    .max_index    (max_index)
  );

  // A query transaction starts a scan: the slave side drops ready next cycle.
  a_query_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (op == wmpa_pkg::OP_QUERY)) |=> !s_tready)
    else $error("slave side still ready after a query transaction");

  // A write never produces a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (op == wmpa_pkg::OP_WRITE) && !m_tvalid) |=> !m_tvalid)
    else $error("result appeared after a write transaction");

  // A result only appears at the end of a scan, while input is held off.
  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a completed scan");

endmodule

[bench/tb.sv]
// Self-checking testbench for the window max pool with argmax core.
`timescale 1ns / 100ps

module tb;
  import wmpa_pkg::*;

  localparam int MAP_ROWS     = DEF_MAX_HEIGHT;
  localparam int MAP_COLS     = DEF_MAX_WIDTH;
  localparam int MAP_CHANS    = DEF_MAX_CHANNELS;
  localparam int KERNEL_MAX   = DEF_MAX_KERNEL;
  localparam int STORE_WORDS  = MAP_ROWS * MAP_COLS * MAP_CHANS;
  // Quiet time covers the longest query, with margin for a trailing write.
  localparam int QUIET_CYCLES = KERNEL_MAX * KERNEL_MAX + 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int NUM_PHASES   = 9;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    op_t                 op;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] sample;
  } pool_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]           index;
  } pool_result_t;

  typedef struct {
    int         height;
    int         width;
    int         chans;
    int         kernel;
    int         stride;
    int         pad;
    idle_mode_t mode;
    int         items;
    bit         hold;
  } phase_t;

  // Clock, reset and DUT ports; every input starts at a known value.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [5:0] row_pos, [11:6] col_pos, [13:12] channel_sel,
                                          // [45:14] sample_value, [47:46] zero
  logic [0:0]             s_tuser = '0;   // [0] opcode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [31:0] max_value, [37:32] max_index, [39:38] zero
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  // Predictor state: register copy and the feature map as the block should hold it.
  cfg_t cfg = '{RST_MAP_HEIGHT, RST_MAP_WIDTH, RST_CHANNEL_COUNT,
                RST_KERNEL_SIZE, RST_WINDOW_STRIDE, RST_PAD_AMOUNT};
  logic signed [SAMPLE_W-1:0] fmap_words [STORE_WORDS];

  // Stimulus side: which map words have been written, so no query reads an unwritten one.
  bit           sample_known [STORE_WORDS];
  pool_item_t   send_queue [$];
  pool_result_t pool_results [$];

  pool_item_t   next_item;
  pool_item_t   taken_item;
  pool_result_t got_result;
  pool_result_t want_result;
  bit           in_taken = 1'b0;
  idle_mode_t   idle_mode = IDLE_NONE;
  bit           hold_req = 1'b0;
  bit           hold_ack = 1'b0;
  int           hold_left = 0;

  int fail_count = 0;
  int writes_seen = 0;
  int queries_seen = 0;
  int results_checked = 0;

  window_max_pool_argmax_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Geometry helpers shared by the predictor and the stimulus
  // ---------------------------------------------------------------------------

  // Dimension registers saturate at the store size.
  function automatic int eff_dim(int v, int top);
    return (v > top) ? top : v;
  endfunction

  // True when (r, q, ch) lies inside the map in use; such positions read the store.
  function automatic bit in_map(int r, int q, int ch);
    int h;
    int w;
    int c;
    h = eff_dim(int'(cfg.map_height), MAP_ROWS);
    w = eff_dim(int'(cfg.map_width), MAP_COLS);
    c = eff_dim(int'(cfg.channel_count), MAP_CHANS);
    return r >= 0 && q >= 0 && ch >= 0 && r < h && q < w && ch < c;
  endfunction

  function automatic int word_addr(int r, int q, int ch);
    return (r * MAP_COLS + q) * MAP_CHANS + ch;
  endfunction

  // Zero kernel acts as 1, oversized kernel clips to the largest window.
  function automatic int kernel_side();
    if (cfg.kernel_size == 0) return 1;
    return eff_dim(int'(cfg.kernel_size), KERNEL_MAX);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: apply one accepted transaction, queue the expected pooling result
  // ---------------------------------------------------------------------------
  task automatic apply_pool_item(pool_item_t it);
    int k;
    int r0;
    int c0;
    int m;
    int n;
    logic signed [SAMPLE_W-1:0] v;
    pool_result_t best;
    if (it.op == OP_WRITE) begin
      writes_seen++;
      // Drop writes outside the configured height, width or channel count.
      if (in_map(it.row, it.col, it.ch))
        fmap_words[word_addr(it.row, it.col, it.ch)] = it.sample;
    end else begin
      queries_seen++;
      k  = kernel_side();
      r0 = int'(it.row) * int'(cfg.window_stride) - int'(cfg.pad_amount);
      c0 = int'(it.col) * int'(cfg.window_stride) - int'(cfg.pad_amount);
      best.value = '0;
      best.index = '0;
      // Scan row-major; padding and off-map positions count as zero; ties keep the first.
      for (m = 0; m < k; m++) begin
        for (n = 0; n < k; n++) begin
          v = '0;
          if (in_map(r0 + m, c0 + n, it.ch))
            v = fmap_words[word_addr(r0 + m, c0 + n, it.ch)];
          if ((m == 0 && n == 0) || v > best.value) begin
            best.value = v;
            best.index = IDX_W'(m * k + n);
          end
        end
      end
      pool_results.push_back(best);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Mix extremes, small values that tie with each other and with padding, and noise.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4, 5: return $urandom_range(0, 6) - 3;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_item(op_t op, int row, int col, int ch, logic [SAMPLE_W-1:0] sample);
    pool_item_t it;
    it.op     = op;
    it.row    = ROW_W'(row);
    it.col    = COL_W'(col);
    it.ch     = CH_W'(ch);
    it.sample = sample;
    if (op == OP_WRITE && in_map(row, col, ch))
      sample_known[word_addr(row, col, ch)] = 1'b1;
    send_queue.push_back(it);
  endtask

  // Fill any never-written map word the window touches, then queue the query itself.
  task automatic queue_query(int row, int col, int ch);
    int k;
    int r0;
    int c0;
    int m;
    int n;
    k  = kernel_side();
    r0 = row * int'(cfg.window_stride) - int'(cfg.pad_amount);
    c0 = col * int'(cfg.window_stride) - int'(cfg.pad_amount);
    for (m = 0; m < k; m++) begin
      for (n = 0; n < k; n++) begin
        if (in_map(r0 + m, c0 + n, ch) && !sample_known[word_addr(r0 + m, c0 + n, ch)])
          queue_item(OP_WRITE, r0 + m, c0 + n, ch, pick_sample());
      end
    end
    // The sample field is ignored on a query; toggle it anyway.
    queue_item(OP_QUERY, row, col, ch, $urandom());
  endtask

  // One random transaction plus any fill writes it needs; count every one queued.
  task automatic queue_random_item(ref int count);
    int h;
    int w;
    int c;
    int step;
    int span_r;
    int span_c;
    int row;
    int col;
    int ch;
    int queued_before;
    queued_before = send_queue.size();
    h = eff_dim(int'(cfg.map_height), MAP_ROWS);
    w = eff_dim(int'(cfg.map_width), MAP_COLS);
    c = eff_dim(int'(cfg.channel_count), MAP_CHANS);
    if ($urandom_range(0, 99) < 40) begin
      if ($urandom_range(0, 9) == 0 || h == 0 || w == 0 || c == 0) begin
        row = $urandom_range(0, 63);
        col = $urandom_range(0, 63);
        ch  = $urandom_range(0, 3);
      end else begin
        row = $urandom_range(0, h - 1);
        col = $urandom_range(0, w - 1);
        ch  = $urandom_range(0, c - 1);
      end
      queue_item(OP_WRITE, row, col, ch, pick_sample());
    end else begin
      step   = (cfg.window_stride == 0) ? 1 : int'(cfg.window_stride);
      span_r = eff_dim((h + 2 * int'(cfg.pad_amount)) / step, 63);
      span_c = eff_dim((w + 2 * int'(cfg.pad_amount)) / step, 63);
      if ($urandom_range(0, 9) == 0) begin
        row = $urandom_range(0, 63);
        col = $urandom_range(0, 63);
      end else begin
        row = $urandom_range(0, span_r);
        col = $urandom_range(0, span_c);
      end
      ch = ($urandom_range(0, 9) == 0 || c == 0) ? $urandom_range(0, 3) : $urandom_range(0, c - 1);
      queue_query(row, col, ch);
    end
    count += send_queue.size() - queued_before;
  endtask

  // Hold off until every queued transaction is accepted and every result has come back.
  task automatic wait_drained();
    while (send_queue.size() != 0 || s_tvalid || pool_results.size() != 0)
      @(posedge clk);
  endtask

  // Two-phase register write; the register takes the value at the access edge.
  task automatic cfg_write(reg_idx_t idx, int value);
    logic [PDATA_W-1:0] word;
    // Upper bits above every register's width carry noise; the block keeps only the low bits.
    word = PDATA_W'(value) | (PDATA_W'($urandom()) << 8);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MAP_HEIGHT:    cfg.map_height    = word[DIM_W-1:0];
      REG_MAP_WIDTH:     cfg.map_width     = word[DIM_W-1:0];
      REG_CHANNEL_COUNT: cfg.channel_count = word[CCNT_W-1:0];
      REG_KERNEL_SIZE:   cfg.kernel_size   = word[KSIZE_W-1:0];
      REG_WINDOW_STRIDE: cfg.window_stride = word[STRIDE_W-1:0];
      REG_PAD_AMOUNT:    cfg.pad_amount    = word[PAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next queued transaction once the previous one is taken.
  // Valid stays high until accepted; gaps are only inserted between transactions.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (send_queue.size() != 0 &&
          !(idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 49) &&
          !(idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7)) begin
        next_item = send_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, next_item.sample, next_item.ch, next_item.col, next_item.row};
        s_tuser  <= next_item.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per phase, plus a long hold-off counted here so the
  // block fills up and stalls its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if ((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 49) ||
                 (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7)) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Input monitor: decode each accepted transaction from the bus and predict.
  always @(posedge clk) begin
    in_taken = !rst && s_tvalid && s_tready;
    if (in_taken) begin
      taken_item.op     = op_t'(s_tuser[0]);
      taken_item.row    = s_tdata[0 +: ROW_W];
      taken_item.col    = s_tdata[ROW_W +: COL_W];
      taken_item.ch     = s_tdata[ROW_W + COL_W +: CH_W];
      taken_item.sample = s_tdata[ROW_W + COL_W + CH_W +: SAMPLE_W];
      apply_pool_item(taken_item);
    end
  end

  // Output monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result.value = m_tdata[0 +: SAMPLE_W];
      got_result.index = m_tdata[SAMPLE_W +: IDX_W];
      if (pool_results.size() == 0) begin
        $error("unexpected result: max_value %0d, max_index %0d",
               got_result.value, got_result.index);
        fail_count++;
      end else begin
        want_result = pool_results.pop_front();
        results_checked++;
        if (got_result.value !== want_result.value) begin
          $error("max_value: expected %0d, actual %0d", want_result.value, got_result.value);
          fail_count++;
        end
        if (got_result.index !== want_result.index) begin
          $error("max_index: expected %0d, actual %0d", want_result.index, got_result.index);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed cases at reset settings, then random phases
  // ---------------------------------------------------------------------------
  initial begin
    phase_t plan [NUM_PHASES];
    int     done;
    bit     paused;
    int     i;

    // height, width, channels, kernel, stride, pad, idling, items, long hold-off
    plan[0] = '{8,  8,  2, 3,  1,  1, IDLE_NONE,     60, 1'b0};
    plan[1] = '{4,  6,  4, 2,  2,  0, IDLE_SENDER,   50, 1'b0};
    // all fields at their top codes: sizes saturate, kernel clips to 8
    plan[2] = '{63, 63, 7, 15, 15, 7, IDLE_RECEIVER, 40, 1'b0};
    // single-position map, zero stride: every output uses the same window
    plan[3] = '{1,  1,  1, 8,  0,  0, IDLE_BOTH,     40, 1'b0};
    // empty map: every write dropped, every position reads zero
    plan[4] = '{0,  5,  1, 2,  1,  0, IDLE_SENDER,   30, 1'b0};
    // zero channels, smallest kernel
    plan[5] = '{5,  3,  0, 1,  3,  2, IDLE_RECEIVER, 30, 1'b0};
    // zero kernel acts as 1
    plan[6] = '{16, 16, 3, 0,  1,  3, IDLE_BOTH,     60, 1'b0};
    plan[7] = '{32, 32, 1, 4,  4,  0, IDLE_NONE,     70, 1'b1};
    plan[8] = '{12, 20, 4, 5,  3,  2, IDLE_BOTH,     60, 1'b0};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes in one window: the positive extreme wins at index 0.
    queue_item(OP_WRITE, 0, 0, 0, 32'h7fff_ffff);
    queue_item(OP_WRITE, 0, 1, 0, 32'h8000_0000);
    queue_item(OP_WRITE, 1, 0, 0, 32'hffff_ffff);
    queue_item(OP_WRITE, 1, 1, 0, 32'h0000_0000);
    queue_query(0, 0, 0);
    // Equal samples: the first in scan order is kept.
    queue_item(OP_WRITE, 0, 2, 0, 32'd5);
    queue_item(OP_WRITE, 0, 3, 0, 32'd5);
    queue_item(OP_WRITE, 1, 2, 0, 32'd5);
    queue_item(OP_WRITE, 1, 3, 0, 32'd5);
    queue_query(0, 1, 0);
    // All negative with a repeated maximum at window indexes 1 and 3.
    queue_item(OP_WRITE, 2, 0, 0, -32'sd5);
    queue_item(OP_WRITE, 2, 1, 0, -32'sd3);
    queue_item(OP_WRITE, 3, 0, 0, -32'sd7);
    queue_item(OP_WRITE, 3, 1, 0, -32'sd3);
    queue_query(1, 0, 0);
    // Writes past the height, the width and the channel count are dropped.
    queue_item(OP_WRITE, 40, 0, 0, 32'h1234_5678);
    queue_item(OP_WRITE, 0, 63, 0, 32'h1234_5678);
    queue_item(OP_WRITE, 0, 0, 2, 32'h1234_5678);
    queue_item(OP_WRITE, 63, 63, 3, 32'hffff_ffff);
    queue_query(0, 0, 0);
    // Channel beyond the count, then a window entirely off the map.
    queue_query(0, 0, 3);
    queue_query(63, 63, 0);

    for (i = 0; i < NUM_PHASES; i++) begin
      // Reconfigure only once the block is idle.
      wait_drained();
      repeat (QUIET_CYCLES) @(posedge clk);
      idle_mode = plan[i].mode;
      cfg_write(REG_MAP_HEIGHT,    plan[i].height);
      cfg_write(REG_MAP_WIDTH,     plan[i].width);
      cfg_write(REG_CHANNEL_COUNT, plan[i].chans);
      cfg_write(REG_KERNEL_SIZE,   plan[i].kernel);
      cfg_write(REG_WINDOW_STRIDE, plan[i].stride);
      cfg_write(REG_PAD_AMOUNT,    plan[i].pad);
      if (plan[i].hold) hold_req = !hold_req;
      done   = 0;
      paused = 1'b0;
      while (done < plan[i].items) begin
        queue_random_item(done);
        // Midway, let the sender pause until every result is back.
        if (!paused && done >= plan[i].items / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (pool_results.size() != 0) begin
      $error("%0d expected results never arrived", pool_results.size());
      fail_count++;
    end

    $display("Run covered %0d sample writes and %0d pooling queries over %0d register settings,",
             writes_seen, queries_seen, NUM_PHASES + 1);
    $display("with %0d result transactions compared field by field.", results_checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #5_000_000;
    $display("Timeout: %0d results still expected", pool_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
